// ===== rtl/core/sobel_gradient_magnitude_unit_defines.svh =====
// assertion helpers used by sobel_gradient_magnitude_unit; they expect aclk and aresetn in scope
`ifndef SOBEL_GRADIENT_MAGNITUDE_UNIT_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SGM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SGM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sgm_pkg.sv =====
package sgm_pkg;

    localparam int MAX_COLS       = 256;
    localparam int MAX_ROWS       = 256;
    localparam int PIXEL_BITS     = 8;
    localparam int DIM_BITS       = 9;
    localparam int COL_ADDR_BITS  = $clog2(MAX_COLS);
    localparam int GRAD_BITS      = 11;
    localparam int MAG_BITS       = 11;
    localparam int SQ_TERM_BITS   = 20;
    localparam int SQ_BITS        = SQ_TERM_BITS + 1;
    localparam int CFG_ADDR_BITS  = 1;

    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_ROWS = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_COLS = 1'b1;

    localparam logic [DIM_BITS-1:0] SIZE_RESET = DIM_BITS'(256);
    localparam logic [MAG_BITS-1:0] MAG_MAX    = MAG_BITS'(1442);

    // one line store entry: the row above and the row two above
    typedef struct packed {
        logic [PIXEL_BITS-1:0] lower;
        logic [PIXEL_BITS-1:0] upper;
    } line_pair_t;

    // one window column, top row first
    typedef struct packed {
        logic [PIXEL_BITS-1:0] top;
        logic [PIXEL_BITS-1:0] mid;
        logic [PIXEL_BITS-1:0] bot;
    } pix_col_t;

    function automatic logic [DIM_BITS-1:0] clamp_size(input logic [DIM_BITS-1:0] v,
                                                       input logic [DIM_BITS-1:0] limit);
        logic [DIM_BITS-1:0] r;
        if (v == '0) begin
            r = DIM_BITS'(1);
        end else if (v > limit) begin
            r = limit;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [GRAD_BITS-1:0] ext_pix(input logic [PIXEL_BITS-1:0] p);
        return $signed({{(GRAD_BITS-PIXEL_BITS){1'b0}}, p});
    endfunction

endpackage

// ===== rtl/core/sgm_line_store.sv =====
module sgm_line_store
    import sgm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [COL_ADDR_BITS-1:0] rd_addr,
    output line_pair_t               rd_data,
    input  logic                     wr_en,
    input  logic [COL_ADDR_BITS-1:0] wr_addr,
    input  line_pair_t               wr_data
);

    line_pair_t mem [MAX_COLS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/sgm_isqrt.sv =====
module sgm_isqrt
    import sgm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SQ_BITS-1:0]  operand,
    output logic                done,
    output logic [MAG_BITS-1:0] root
);

    localparam int STEP_BITS = $clog2(MAG_BITS);
    localparam logic [SQ_BITS-1:0] BIT_INIT = SQ_BITS'(1) << (2 * (MAG_BITS - 1));

    logic [SQ_BITS-1:0]   rem_reg, rem_next;
    logic [SQ_BITS-1:0]   res_reg, res_next;
    logic [SQ_BITS-1:0]   bit_reg, bit_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SQ_BITS:0]     trial;

    // one result bit per cycle, restoring digit recurrence
    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        if (start) begin
            rem_next  = operand;
            res_next  = '0;
            bit_next  = BIT_INIT;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if ({1'b0, rem_reg} >= trial) begin
                rem_next = rem_reg - trial[SQ_BITS-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            step_next = step_reg + STEP_BITS'(1);
            if (step_reg == STEP_BITS'(MAG_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            rem_reg  <= rem_next;
            res_reg  <= res_next;
            bit_reg  <= bit_next;
        end
    end

    assign done = done_reg;
    assign root = res_reg[MAG_BITS-1:0];

endmodule

// ===== rtl/core/sobel_gradient_magnitude_unit.sv =====
// 3x3 sobel edge detector over a zero-padded image. Send one pixel per position of the
// (image_rows+2) x (image_cols+2) output grid in raster order; the pixel is ignored outside
// the image. Each transaction returns grad_x, grad_y, their magnitude (floor square root of
// the sum of squares) and a last_of_frame flag on the final grid position. Set image_rows
// and image_cols (1..256, 0 counts as 1, larger counts as 256) while the block is idle; any
// write restarts the frame. The two previous rows live in one 256 x 16 synchronous-read
// memory. A pixel passes through a memory read and write-back state, a squaring state, a
// sum state that starts the square root, a wait state until the bit-by-bit square root
// finishes, and a hold state that loads the output register, staying there while that
// register is full and not being drained. Only one pixel is in flight at a time: a new
// pixel is taken as soon as the previous result is loaded into the output register, even
// if that result has not been taken yet.
`include "sobel_gradient_magnitude_unit_defines.svh"

module sobel_gradient_magnitude_unit
    import sgm_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [DIM_BITS-1:0]         cfg_wr_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [PIXEL_BITS-1:0]       s_pixel,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [GRAD_BITS-1:0] m_grad_x,
    output logic signed [GRAD_BITS-1:0] m_grad_y,
    output logic [MAG_BITS-1:0]         m_magnitude,
    output logic                        m_last_of_frame
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_HOLD
    } state_t;

    state_t state_reg, state_next;

    logic [DIM_BITS-1:0]      image_rows_reg, image_rows_next;
    logic [DIM_BITS-1:0]      image_cols_reg, image_cols_next;
    logic [DIM_BITS-1:0]      row_reg, row_next;
    logic [DIM_BITS-1:0]      col_reg, col_next;
    pix_col_t                 win0_reg, win0_next;
    pix_col_t                 win1_reg, win1_next;

    logic [PIXEL_BITS-1:0]    pix_reg, pix_next;
    logic                     col_in_reg, col_in_next;
    logic                     ge1_reg, ge1_next;
    logic                     ge2_reg, ge2_next;
    logic                     first_reg, first_next;
    logic                     last_reg, last_next;
    logic [COL_ADDR_BITS-1:0] addr_reg, addr_next;

    logic signed [GRAD_BITS-1:0] gx_reg, gx_next;
    logic signed [GRAD_BITS-1:0] gy_reg, gy_next;
    logic [SQ_TERM_BITS-1:0]     sqx_reg, sqx_next;
    logic [SQ_TERM_BITS-1:0]     sqy_reg, sqy_next;

    logic                        m_valid_reg, m_valid_next;
    logic signed [GRAD_BITS-1:0] m_grad_x_reg, m_grad_x_next;
    logic signed [GRAD_BITS-1:0] m_grad_y_reg, m_grad_y_next;
    logic [MAG_BITS-1:0]         m_magnitude_reg, m_magnitude_next;
    logic                        m_last_reg, m_last_next;

    logic [DIM_BITS-1:0]  rows_eff, cols_eff;
    logic                 in_xact;
    logic                 col_inside;
    line_pair_t           rd_pair;
    line_pair_t           wr_pair;
    logic                 store_wr_en;
    logic [PIXEL_BITS-1:0] up_pix, lo_pix;
    pix_col_t             wnd0, wnd1;
    logic signed [2*GRAD_BITS-1:0] prod_x, prod_y;
    logic                 sqrt_start;
    logic [SQ_BITS-1:0]   sqrt_operand;
    logic                 sqrt_done;
    logic [MAG_BITS-1:0]  sqrt_root;

    assign rows_eff   = clamp_size(image_rows_reg, DIM_BITS'(MAX_ROWS));
    assign cols_eff   = clamp_size(image_cols_reg, DIM_BITS'(MAX_COLS));
    assign s_ready    = (state_reg == ST_IDLE);
    assign in_xact    = s_valid && s_ready;
    assign col_inside = (col_reg < cols_eff);

    sgm_line_store u_line_store (
        .aclk    (aclk),
        .rd_en   (in_xact && col_inside),
        .rd_addr (col_reg[COL_ADDR_BITS-1:0]),
        .rd_data (rd_pair),
        .wr_en   (store_wr_en),
        .wr_addr (addr_reg),
        .wr_data (wr_pair)
    );

    // rows before the image and columns past it read as zero; the window is cleared at column 0
    assign up_pix = (col_in_reg && ge1_reg) ? rd_pair.upper : '0;
    assign lo_pix = (col_in_reg && ge2_reg) ? rd_pair.lower : '0;
    assign wnd0   = first_reg ? '0 : win0_reg;
    assign wnd1   = first_reg ? '0 : win1_reg;

    assign store_wr_en   = (state_reg == ST_READ) && col_in_reg;
    assign wr_pair.lower = up_pix;
    assign wr_pair.upper = pix_reg;

    assign prod_x       = gx_reg * gx_reg;
    assign prod_y       = gy_reg * gy_reg;
    assign sqrt_start   = (state_reg == ST_SUM);
    assign sqrt_operand = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    sgm_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .operand (sqrt_operand),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    always_comb begin
        state_next       = state_reg;
        image_rows_next  = image_rows_reg;
        image_cols_next  = image_cols_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        win0_next        = win0_reg;
        win1_next        = win1_reg;
        pix_next         = pix_reg;
        col_in_next      = col_in_reg;
        ge1_next         = ge1_reg;
        ge2_next         = ge2_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        addr_next        = addr_reg;
        gx_next          = gx_reg;
        gy_next          = gy_reg;
        sqx_next         = sqx_reg;
        sqy_next         = sqy_reg;
        m_valid_next     = m_valid_reg;
        m_grad_x_next    = m_grad_x_reg;
        m_grad_y_next    = m_grad_y_reg;
        m_magnitude_next = m_magnitude_reg;
        m_last_next      = m_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xact) begin
                    col_in_next = col_inside;
                    pix_next    = (col_inside && row_reg < rows_eff) ? s_pixel : '0;
                    ge1_next    = (row_reg >= DIM_BITS'(1));
                    ge2_next    = (row_reg >= DIM_BITS'(2));
                    first_next  = (col_reg == '0);
                    addr_next   = col_reg[COL_ADDR_BITS-1:0];
                    last_next   = (row_reg >= rows_eff + DIM_BITS'(1)) &&
                                  (col_reg >= cols_eff + DIM_BITS'(1));
                    if (col_reg >= cols_eff + DIM_BITS'(1)) begin
                        col_next = '0;
                        row_next = (row_reg >= rows_eff + DIM_BITS'(1)) ? '0
                                 : row_reg + DIM_BITS'(1);
                    end else begin
                        col_next = col_reg + DIM_BITS'(1);
                    end
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                gx_next = (ext_pix(lo_pix) - ext_pix(wnd0.top))
                        + ((ext_pix(up_pix) - ext_pix(wnd0.mid)) <<< 1)
                        + (ext_pix(pix_reg) - ext_pix(wnd0.bot));
                gy_next = (ext_pix(wnd0.bot) - ext_pix(wnd0.top))
                        + ((ext_pix(wnd1.bot) - ext_pix(wnd1.top)) <<< 1)
                        + (ext_pix(pix_reg) - ext_pix(lo_pix));
                win0_next     = wnd1;
                win1_next.top = lo_pix;
                win1_next.mid = up_pix;
                win1_next.bot = pix_reg;
                state_next    = ST_SQUARE;
            end
            ST_SQUARE: begin
                sqx_next   = prod_x[SQ_TERM_BITS-1:0];
                sqy_next   = prod_y[SQ_TERM_BITS-1:0];
                state_next = ST_SUM;
            end
            ST_SUM: begin
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (sqrt_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                // output register free or being drained this cycle
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_grad_x_next    = gx_reg;
                    m_grad_y_next    = gy_reg;
                    m_magnitude_next = sqrt_root;
                    m_last_next      = last_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a register write restarts the frame
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_IMAGE_ROWS: image_rows_next = cfg_wr_data;
                REG_IMAGE_COLS: image_cols_next = cfg_wr_data;
                default:        image_rows_next = image_rows_reg;
            endcase
            row_next  = '0;
            col_next  = '0;
            win0_next = '0;
            win1_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            image_rows_reg <= SIZE_RESET;
            image_cols_reg <= SIZE_RESET;
            row_reg        <= '0;
            col_reg        <= '0;
            win0_reg       <= '0;
            win1_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            image_rows_reg  <= image_rows_next;
            image_cols_reg  <= image_cols_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            win0_reg        <= win0_next;
            win1_reg        <= win1_next;
            m_valid_reg     <= m_valid_next;
            pix_reg         <= pix_next;
            col_in_reg      <= col_in_next;
            ge1_reg         <= ge1_next;
            ge2_reg         <= ge2_next;
            first_reg       <= first_next;
            last_reg        <= last_next;
            addr_reg        <= addr_next;
            gx_reg          <= gx_next;
            gy_reg          <= gy_next;
            sqx_reg         <= sqx_next;
            sqy_reg         <= sqy_next;
            m_grad_x_reg    <= m_grad_x_next;
            m_grad_y_reg    <= m_grad_y_next;
            m_magnitude_reg <= m_magnitude_next;
            m_last_reg      <= m_last_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_grad_x        = m_grad_x_reg;
    assign m_grad_y        = m_grad_y_reg;
    assign m_magnitude     = m_magnitude_reg;
    assign m_last_of_frame = m_last_reg;

    `SGM_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "second item taken while busy")
    `SGM_ASSERT_SAME(a_root_in_wait, sqrt_done, state_reg == ST_ROOT, "root done outside wait")
    `SGM_ASSERT_SAME(a_mag_range, m_valid, m_magnitude <= MAG_MAX, "magnitude out of range")
    `SGM_ASSERT_SAME(a_grid_range, 1'b1,
        (col_reg <= cols_eff + DIM_BITS'(1)) && (row_reg <= rows_eff + DIM_BITS'(1)),
        "grid position beyond padded frame")

endmodule

// ===== test/tb_sobel_gradient_magnitude_unit.sv =====
`timescale 1ns / 1ps

module tb_sobel_gradient_magnitude_unit;
    import sgm_pkg::*;

    localparam int DRAIN_CYCLES  = 24;
    localparam int RANDOM_PIXELS = 350;
    localparam int CALM_PIXELS   = 120;

    typedef enum int {
        PAT_RANDOM,
        PAT_EXTREME,
        PAT_RAMP
    } pixel_pattern_t;

    typedef struct packed {
        logic signed [GRAD_BITS-1:0] grad_x;
        logic signed [GRAD_BITS-1:0] grad_y;
        logic [MAG_BITS-1:0]         magnitude;
        logic                        last_of_frame;
    } gradient_result_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [CFG_ADDR_BITS-1:0]    cfg_addr;
    logic [DIM_BITS-1:0]         cfg_wr_data;
    logic                        s_valid;
    logic                        s_ready;
    logic [PIXEL_BITS-1:0]       s_pixel;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [GRAD_BITS-1:0] m_grad_x;
    logic signed [GRAD_BITS-1:0] m_grad_y;
    logic [MAG_BITS-1:0]         m_magnitude;
    logic                        m_last_of_frame;

    logic                        stall_enable;

    // shadow of the block: size registers, frame position, line stores, window
    logic [DIM_BITS-1:0]   rows_reg = SIZE_RESET;
    logic [DIM_BITS-1:0]   cols_reg = SIZE_RESET;
    logic [DIM_BITS-1:0]   frame_row = '0;
    logic [DIM_BITS-1:0]   frame_col = '0;
    logic [PIXEL_BITS-1:0] row_above [MAX_COLS] = '{default: '0};
    logic [PIXEL_BITS-1:0] row_two_above [MAX_COLS] = '{default: '0};
    // window columns c-2 and c-1, top (row r-2) first
    logic [PIXEL_BITS-1:0] win_left [3] = '{default: '0};
    logic [PIXEL_BITS-1:0] win_mid [3] = '{default: '0};

    gradient_result_t pending_gradients[$];

    int errors = 0;
    int pixels_sent = 0;
    int results_checked = 0;
    int size_writes = 0;

    sobel_gradient_magnitude_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_grad_x        (m_grad_x),
        .m_grad_y        (m_grad_y),
        .m_magnitude     (m_magnitude),
        .m_last_of_frame (m_last_of_frame)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    initial begin
        #10_000_000;
        $display("sobel_gradient_magnitude_unit: mismatch");
        $finish;
    end

    function automatic int visible_size(input logic [DIM_BITS-1:0] value, input int limit);
        if (value == '0) begin
            return 1;
        end
        return (value > limit) ? limit : int'(value);
    endfunction

    function automatic int frame_len();
        return (visible_size(rows_reg, MAX_ROWS) + 2) * (visible_size(cols_reg, MAX_COLS) + 2);
    endfunction

    function automatic int unsigned floor_sqrt(input int unsigned value);
        int unsigned root;
        int unsigned trial;
        root = 0;
        for (int b = MAG_BITS - 1; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= value) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic gradient_result_t compute_gradients(input logic [PIXEL_BITS-1:0] pix);
        int n_rows;
        int n_cols;
        int r;
        int c;
        int cur;
        int above;
        int two_above;
        int w [3][3];
        int gx;
        int gy;
        gradient_result_t res;
        n_rows = visible_size(rows_reg, MAX_ROWS);
        n_cols = visible_size(cols_reg, MAX_COLS);
        r = frame_row;
        c = frame_col;
        cur = 0;
        above = 0;
        two_above = 0;
        // padding columns to the right never touch the line stores
        if (c < n_cols) begin
            if (r < n_rows) begin
                cur = pix;
            end
            if (r >= 1) begin
                above = row_above[c];
            end
            if (r >= 2) begin
                two_above = row_two_above[c];
            end
            row_two_above[c] = PIXEL_BITS'(above);
            row_above[c] = PIXEL_BITS'(cur);
        end
        if (c == 0) begin
            for (int i = 0; i < 3; i++) begin
                win_left[i] = '0;
                win_mid[i] = '0;
            end
        end
        for (int i = 0; i < 3; i++) begin
            w[i][0] = win_left[i];
            w[i][1] = win_mid[i];
        end
        w[0][2] = two_above;
        w[1][2] = above;
        w[2][2] = cur;
        gx = (w[0][2] - w[0][0]) + 2 * (w[1][2] - w[1][0]) + (w[2][2] - w[2][0]);
        gy = (w[2][0] - w[0][0]) + 2 * (w[2][1] - w[0][1]) + (w[2][2] - w[0][2]);
        win_left = win_mid;
        for (int i = 0; i < 3; i++) begin
            win_mid[i] = PIXEL_BITS'(w[i][2]);
        end
        res.grad_x = GRAD_BITS'(gx);
        res.grad_y = GRAD_BITS'(gy);
        res.magnitude = MAG_BITS'(floor_sqrt(gx * gx + gy * gy));
        res.last_of_frame = (r == n_rows + 1) && (c == n_cols + 1);
        if (c == n_cols + 1) begin
            frame_col = '0;
            frame_row = (r == n_rows + 1) ? '0 : DIM_BITS'(r + 1);
        end else begin
            frame_col = DIM_BITS'(c + 1);
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        m_ready <= !(stall_enable && ($urandom_range(99) < 18));
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        gradient_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_gradients.size() == 0) begin
                $display("%0t: unexpected result expected none actual gx=%0d gy=%0d mag=%0d",
                         $time, m_grad_x, m_grad_y, m_magnitude);
                errors++;
            end else begin
                want = pending_gradients.pop_front();
                check_field("grad_x", $signed(want.grad_x), m_grad_x);
                check_field("grad_y", $signed(want.grad_y), m_grad_y);
                check_field("magnitude", want.magnitude, m_magnitude);
                check_field("last_of_frame", want.last_of_frame, m_last_of_frame);
                results_checked++;
            end
        end
    end

    // long gaps can outlast the busy time so valid is also seen low while ready
    task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix);
        if (stall_enable && ($urandom_range(99) < 18)) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= pix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_gradients.push_back(compute_gradients(pix));
        pixels_sent++;
    endtask

    task automatic send_pixels(input int count, input pixel_pattern_t pattern);
        logic [PIXEL_BITS-1:0] pix;
        for (int i = 0; i < count; i++) begin
            case (pattern)
                PAT_EXTREME: begin
                    pix = $urandom_range(1) ? '1 : '0;
                end
                PAT_RAMP: begin
                    pix = PIXEL_BITS'(i * 7);
                end
                default: begin
                    pix = PIXEL_BITS'($urandom);
                end
            endcase
            send_pixel(pix);
        end
    endtask

    task automatic drain_results();
        while (pending_gradients.size() != 0) @(posedge aclk);
    endtask

    // size writes restart the frame, so they only happen with nothing in flight
    task automatic write_size(input logic [CFG_ADDR_BITS-1:0] idx,
                              input logic [DIM_BITS-1:0] value);
        s_valid <= 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_IMAGE_ROWS) begin
            rows_reg = value;
        end else begin
            cols_reg = value;
        end
        frame_row = '0;
        frame_col = '0;
        for (int i = 0; i < 3; i++) begin
            win_left[i] = '0;
            win_mid[i] = '0;
        end
        size_writes++;
    endtask

    // first full-width row at the reset size and the start of the next, cut off by a write
    task automatic test_reset_size_frame();
        send_pixels(MAX_COLS + 2 + 16, PAT_RANDOM);
    endtask

    // bright right column of a 3x3 image gives the largest grad_x of both signs
    task automatic test_column_edges();
        write_size(REG_IMAGE_ROWS, DIM_BITS'(3));
        write_size(REG_IMAGE_COLS, DIM_BITS'(3));
        for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 5; c++) begin
                if (r < 3 && c < 3) begin
                    send_pixel((c == 2) ? '1 : '0);
                end else begin
                    send_pixel(PIXEL_BITS'($urandom));
                end
            end
        end
    endtask

    task automatic test_clamped_sizes();
        // zero counts as one; two frames back to back check the wrap
        write_size(REG_IMAGE_ROWS, '0);
        write_size(REG_IMAGE_COLS, '0);
        send_pixels(2 * frame_len(), PAT_EXTREME);
        // tall image, rows above the limit
        write_size(REG_IMAGE_ROWS, DIM_BITS'(300));
        send_pixels(frame_len(), PAT_RANDOM);
        // wide image, all ones in the column register: past the padding into the next row
        write_size(REG_IMAGE_ROWS, DIM_BITS'(1));
        write_size(REG_IMAGE_COLS, '1);
        send_pixels(MAX_COLS + 2 + 8, PAT_RAMP);
    endtask

    task automatic test_random_frames();
        int start_count;
        int rows;
        int cols;
        int len;
        int count;
        pixel_pattern_t pattern;
        start_count = pixels_sent;
        stall_enable <= 1'b0;
        while (pixels_sent - start_count < RANDOM_PIXELS) begin
            if (pixels_sent - start_count >= CALM_PIXELS) begin
                stall_enable <= 1'b1;
            end
            rows = ($urandom_range(9) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 6);
            cols = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 10);
            case ($urandom_range(3))
                0: begin
                    write_size(REG_IMAGE_ROWS, DIM_BITS'(rows));
                end
                1: begin
                    write_size(REG_IMAGE_COLS, DIM_BITS'(cols));
                end
                default: begin
                    write_size(REG_IMAGE_ROWS, DIM_BITS'(rows));
                    write_size(REG_IMAGE_COLS, DIM_BITS'(cols));
                end
            endcase
            pattern = pixel_pattern_t'($urandom_range(2));
            len = frame_len();
            // some frames are abandoned part way through by the next write
            if ($urandom_range(4) == 0) begin
                count = $urandom_range(1, len - 1);
            end else begin
                count = len * $urandom_range(1, 2);
            end
            // the last frame is cut to what is left of the budget
            if (count > RANDOM_PIXELS - (pixels_sent - start_count)) begin
                count = RANDOM_PIXELS - (pixels_sent - start_count);
            end
            send_pixels(count, pattern);
        end
        stall_enable <= 1'b1;
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_pixel <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr <= REG_IMAGE_ROWS;
        cfg_wr_data <= '0;
        m_ready <= 1'b0;
        stall_enable <= 1'b1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_size_frame();
        test_column_edges();
        test_clamped_sizes();
        test_random_frames();
        s_valid <= 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("run covered %0d pixels across %0d size writes, %0d results compared",
                 pixels_sent, size_writes, results_checked);
        if (errors == 0) begin
            $display("sobel_gradient_magnitude_unit: match");
        end else begin
            $display("sobel_gradient_magnitude_unit: mismatch");
        end
        $finish;
    end

endmodule
